/* hdl/gbb_pkg.sv */
// Shared types, constants and helpers for the glyph batch blitter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package gbb_pkg;

    localparam int MaxGlyphRows = 64;
    localparam int AddrBits     = 32;
    localparam int RowsW        = $clog2(MaxGlyphRows + 1);
    localparam logic [31:0] AddrMask = 32'((64'd1 << AddrBits) - 64'd1);

    // power of two, so the queue pointers wrap by themselves
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    localparam logic [1:0] ActSetPen = 2'd0;
    localparam logic [1:0] ActGlyph  = 2'd1;
    localparam logic [1:0] ActRow    = 2'd2;

    localparam logic [3:0] OpClear  = 4'd0;
    localparam logic [3:0] OpNotSrc = 4'd3;
    localparam logic [3:0] OpInvert = 4'd5;
    localparam logic [3:0] OpSrc    = 4'd12;
    localparam logic [3:0] OpSet    = 4'd15;

    localparam logic [2:0] CfgLineBytes = 3'd0;
    localparam logic [2:0] CfgFrameBase = 3'd1;
    localparam logic [2:0] CfgOriginX   = 3'd2;
    localparam logic [2:0] CfgOriginY   = 3'd3;
    localparam logic [2:0] CfgRasterOp  = 3'd4;

    localparam logic KindStart = 1'b0;
    localparam logic KindRow   = 1'b1;

    // x and y are signed 17-bit pixel/line positions including the origin
    typedef struct packed {
        logic        kind;
        logic        skip;
        logic [3:0]  op;
        logic [16:0] x;
        logic [16:0] y;
        logic [4:0]  width;
        logic        last;
        logic [15:0] src;
        logic [31:0] dst;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic avail;
    } t_q_status;

    function automatic logic op_supported(input logic [3:0] op);
        return (op == OpClear) || (op == OpNotSrc) || (op == OpInvert) ||
               (op == OpSrc) || (op == OpSet);
    endfunction

endpackage

/* hdl/glyph_batch_raster_blit_unit.sv */
// Top level of the glyph batch blitter: config registers, front, queue, back.
// Depends on gbb_pkg, gbb_front, gbb_queue, gbb_back.
//
//   channel   handshake                 payload
//   input     i_valid / o_ready         i_action .. i_dest_word
//   output    o_valid / i_ready         o_kind .. o_last
//   config    i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; an accepted word is
// queued at acceptance and taken from the queue by the back end into the output register.
// The back end does one multiply-add per glyph start and one merge per row.
// Reset is synchronous, active low; no clearing pass.
// A stalled output holds the back end; the two-entry queue then fills and
// drops o_ready.
`timescale 1ns / 1ps

module glyph_batch_raster_blit_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_move_x,
    input  logic [15:0] i_move_y,
    input  logic [4:0]  i_glyph_width,
    input  logic [6:0]  i_glyph_height,
    input  logic        i_has_source,
    input  logic [15:0] i_source_row,
    input  logic [31:0] i_dest_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic        o_skip,
    output logic [31:0] o_address,
    output logic [31:0] o_write_data,
    output logic        o_wide,
    output logic [31:0] o_next_address,
    output logic        o_last
);

    logic [15:0] r_line_bytes;
    logic [31:0] r_frame_base;
    logic [11:0] r_origin_x;
    logic [11:0] r_origin_y;
    logic [3:0]  r_raster_op;

    gbb_pkg::t_q_status w_qstat;
    gbb_pkg::t_cmd      w_push_cmd;
    gbb_pkg::t_cmd      w_head;
    logic               w_push;
    logic               w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= 16'd128;
            r_frame_base <= '0;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_raster_op  <= gbb_pkg::OpClear;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gbb_pkg::CfgLineBytes: r_line_bytes <= i_cfg_data[15:0];
                gbb_pkg::CfgFrameBase: r_frame_base <= i_cfg_data;
                gbb_pkg::CfgOriginX:   r_origin_x   <= i_cfg_data[11:0];
                gbb_pkg::CfgOriginY:   r_origin_y   <= i_cfg_data[11:0];
                gbb_pkg::CfgRasterOp:  r_raster_op  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    gbb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_move_x       (i_move_x),
        .i_move_y       (i_move_y),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_has_source   (i_has_source),
        .i_source_row   (i_source_row),
        .i_dest_word    (i_dest_word),
        .i_origin_x     (r_origin_x),
        .i_origin_y     (r_origin_y),
        .i_raster_op    (r_raster_op),
        .i_qstat        (w_qstat),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    gbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_qstat (w_qstat),
        .o_head  (w_head)
    );

    gbb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qstat        (w_qstat),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_line_bytes   (r_line_bytes),
        .i_frame_base   (r_frame_base),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_skip         (o_skip),
        .o_address      (o_address),
        .o_write_data   (o_write_data),
        .o_wide         (o_wide),
        .o_next_address (o_next_address),
        .o_last         (o_last)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qstat.avail)
        else $error("queue pop while empty");

    a_narrow_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind && !o_wide) |-> (o_write_data[31:16] == 16'h0))
        else $error("narrow row write has upper bits set");

    a_start_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> (o_next_address == o_address && !o_last))
        else $error("glyph start answer malformed");

endmodule

/* hdl/gbb_front.sv */
// Front end: accepts input words, tracks pen and open rows, queues commands.
// Depends on gbb_pkg.
`timescale 1ns / 1ps

module gbb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [15:0]        i_move_x,
    input  logic [15:0]        i_move_y,
    input  logic [4:0]         i_glyph_width,
    input  logic [6:0]         i_glyph_height,
    input  logic               i_has_source,
    input  logic [15:0]        i_source_row,
    input  logic [31:0]        i_dest_word,
    input  logic [11:0]        i_origin_x,
    input  logic [11:0]        i_origin_y,
    input  logic [3:0]         i_raster_op,
    input  gbb_pkg::t_q_status i_qstat,
    output logic               o_push,
    output gbb_pkg::t_cmd      o_cmd
);

    logic [15:0]             r_pen_x;
    logic [15:0]             r_pen_y;
    logic [gbb_pkg::RowsW-1:0] r_rows_left;

    logic [15:0]             n_pen_x;
    logic [15:0]             n_pen_y;
    logic                    w_accept;
    logic                    w_skip;
    logic [4:0]              w_width;
    logic [gbb_pkg::RowsW-1:0] w_rows;

    assign o_ready  = !i_qstat.full;
    assign w_accept = i_valid && o_ready;
    assign n_pen_x  = r_pen_x + i_move_x;
    assign n_pen_y  = r_pen_y + i_move_y;

    assign w_skip = !gbb_pkg::op_supported(i_raster_op) || !i_has_source ||
                    (i_glyph_height == 7'd0);

    always_comb begin
        if (i_glyph_width == 5'd0) begin
            w_width = 5'd1;
        end else if (i_glyph_width > 5'd16) begin
            w_width = 5'd16;
        end else begin
            w_width = i_glyph_width;
        end
        if (32'(i_glyph_height) > gbb_pkg::MaxGlyphRows) begin
            w_rows = gbb_pkg::RowsW'(gbb_pkg::MaxGlyphRows);
        end else begin
            w_rows = gbb_pkg::RowsW'(i_glyph_height);
        end
    end

    always_comb begin
        o_cmd.kind  = (i_action == gbb_pkg::ActRow) ? gbb_pkg::KindRow : gbb_pkg::KindStart;
        o_cmd.skip  = w_skip;
        o_cmd.op    = i_raster_op;
        o_cmd.x     = {n_pen_x[15], n_pen_x} + {5'd0, i_origin_x};
        o_cmd.y     = {n_pen_y[15], n_pen_y} + {5'd0, i_origin_y};
        o_cmd.width = w_width;
        o_cmd.last  = (r_rows_left == gbb_pkg::RowsW'(1));
        o_cmd.src   = i_source_row;
        o_cmd.dst   = i_dest_word;
        case (i_action)
            gbb_pkg::ActGlyph: o_push = w_accept;
            gbb_pkg::ActRow:   o_push = w_accept && (r_rows_left != '0);
            default:           o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_rows_left <= '0;
        end else if (w_accept) begin
            case (i_action)
                gbb_pkg::ActSetPen: begin
                    r_pen_x <= i_move_x;
                    r_pen_y <= i_move_y;
                end
                gbb_pkg::ActGlyph: begin
                    r_pen_x     <= n_pen_x;
                    r_pen_y     <= n_pen_y;
                    r_rows_left <= w_skip ? '0 : w_rows;
                end
                gbb_pkg::ActRow: begin
                    if (r_rows_left != '0) begin
                        r_rows_left <= r_rows_left - gbb_pkg::RowsW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hdl/gbb_queue.sv */
// Short command queue between the front end and the raster back end.
// Depends on gbb_pkg.
`timescale 1ns / 1ps

module gbb_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gbb_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output gbb_pkg::t_q_status o_qstat,
    output gbb_pkg::t_cmd      o_head
);

    gbb_pkg::t_cmd             r_mem [gbb_pkg::QueueDepth];
    logic [gbb_pkg::QPtrW-1:0] r_wr_ptr;
    logic [gbb_pkg::QPtrW-1:0] r_rd_ptr;
    logic [gbb_pkg::QCntW-1:0] r_count;

    assign o_qstat.full  = (r_count == gbb_pkg::QCntW'(gbb_pkg::QueueDepth));
    assign o_qstat.avail = (r_count != '0);
    assign o_head        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + gbb_pkg::QPtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + gbb_pkg::QPtrW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + gbb_pkg::QCntW'(1);
                2'b01:   r_count <= r_count - gbb_pkg::QCntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/gbb_back.sv */
// Back end: address generation for glyph starts and row merges with the raster op.
// Depends on gbb_pkg; drives the registered output word.
`timescale 1ns / 1ps

module gbb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gbb_pkg::t_q_status i_qstat,
    input  gbb_pkg::t_cmd      i_head,
    output logic               o_pop,
    input  logic [15:0]        i_line_bytes,
    input  logic [31:0]        i_frame_base,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic               o_skip,
    output logic [31:0]        o_address,
    output logic [31:0]        o_write_data,
    output logic               o_wide,
    output logic [31:0]        o_next_address,
    output logic               o_last
);

    logic [31:0] r_row_addr;
    logic [3:0]  r_skew;
    logic [4:0]  r_width;
    logic        r_wide;
    logic [3:0]  r_op;

    logic        r_valid;
    logic        r_kind;
    logic        r_skip;
    logic [31:0] r_addr;
    logic [31:0] r_data;
    logic        r_owide;
    logic [31:0] r_next;
    logic        r_last;

    logic signed [33:0] w_prod;
    logic signed [12:0] w_word;
    logic [31:0]        w_start_addr;
    logic [3:0]         w_skew;
    logic               w_start_wide;
    logic [31:0]        w_mask;
    logic [31:0]        w_src;
    logic [31:0]        w_dst;
    logic [31:0]        w_merge;
    logic [31:0]        w_row_next;

    assign o_pop = i_qstat.avail && (!r_valid || i_ready);

    // glyph start: frame_base + Y * line_bytes + 2 * floor(X / 16)
    assign w_prod       = $signed(i_head.y) * $signed({1'b0, i_line_bytes});
    assign w_word       = 13'($signed(i_head.x) >>> 4);
    assign w_skew       = i_head.x[3:0];
    assign w_start_addr = (i_frame_base + w_prod[31:0] + {{18{w_word[12]}}, w_word, 1'b0})
                          & gbb_pkg::AddrMask;
    assign w_start_wide = ({2'b0, w_skew} + {1'b0, i_head.width}) > 6'd16;

    always_comb begin
        if (r_wide) begin
            w_mask = (32'hFFFF_FFFF << (6'd32 - {1'b0, r_width})) >> r_skew;
            w_src  = {16'h0, i_head.src} << (5'd16 - {1'b0, r_skew});
            w_dst  = i_head.dst;
        end else begin
            w_mask = {16'h0, (16'hFFFF << (5'd16 - r_width)) >> r_skew};
            w_src  = {16'h0, i_head.src >> r_skew};
            w_dst  = {16'h0, i_head.dst[15:0]};
        end
        case (r_op)
            gbb_pkg::OpClear:  w_merge = w_dst & ~w_mask;
            gbb_pkg::OpNotSrc: w_merge = (w_dst | w_mask) ^ w_src;
            gbb_pkg::OpInvert: w_merge = w_dst ^ w_mask;
            gbb_pkg::OpSrc:    w_merge = (w_dst & ~w_mask) | w_src;
            default:           w_merge = w_dst | w_mask;
        endcase
    end

    assign w_row_next = (r_row_addr + {16'h0, i_line_bytes}) & gbb_pkg::AddrMask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_addr <= '0;
            r_skew     <= '0;
            r_width    <= 5'd1;
            r_wide     <= 1'b0;
            r_op       <= gbb_pkg::OpClear;
            r_valid    <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_kind  <= i_head.kind;
            if (i_head.kind == gbb_pkg::KindStart) begin
                r_row_addr <= w_start_addr;
                r_skew     <= w_skew;
                r_width    <= i_head.width;
                r_wide     <= w_start_wide;
                r_op       <= i_head.op;
                r_skip     <= i_head.skip;
                r_addr     <= w_start_addr;
                r_data     <= '0;
                r_owide    <= w_start_wide;
                r_next     <= w_start_addr;
                r_last     <= 1'b0;
            end else begin
                r_row_addr <= w_row_next;
                r_skip     <= 1'b0;
                r_addr     <= r_row_addr;
                r_data     <= w_merge;
                r_owide    <= r_wide;
                r_next     <= w_row_next;
                r_last     <= i_head.last;
            end
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_skip         = r_skip;
    assign o_address      = r_addr;
    assign o_write_data   = r_data;
    assign o_wide         = r_owide;
    assign o_next_address = r_next;
    assign o_last         = r_last;

endmodule
